@@ sv/vrp_pkg.sv @@
// Shared types and constants for the VP8 RTP packetizer.
// No dependencies; imported by every module of the block.
`default_nettype none

package vrp_pkg;

   localparam int MTU_W     = 16;
   localparam int PID_W     = 15;
   localparam int HDR_MAX   = 4;
   localparam int HDR_IDX_W = 2;
   localparam int HDR_CNT_W = 3;
   localparam int QDEPTH    = 4;
   localparam int QPTR_W    = 2;
   localparam int QCNT_W    = 3;

   // register indexes on the csr port
   localparam logic CSR_MTU    = 1'b0;
   localparam logic CSR_PID_EN = 1'b1;

   // request action codes
   localparam logic ACT_DATA    = 1'b0;
   localparam logic ACT_LOAD_ID = 1'b1;

   // payload descriptor bits
   localparam logic [7:0] HDR_S = 8'h10;
   localparam logic [7:0] HDR_X = 8'h80;
   localparam logic [7:0] HDR_I = 8'h80;
   localparam logic [7:0] HDR_M = 8'h80;

   localparam logic [MTU_W-1:0]     MTU_RESET       = 16'd1200;
   localparam logic [PID_W-1:0]     PID_SHORT_LIMIT = 15'd128;
   localparam logic [HDR_CNT_W-1:0] HSIZE_BASIC     = 3'd1;
   localparam logic [HDR_CNT_W-1:0] HSIZE_SHORT_ID  = 3'd3;
   localparam logic [HDR_CNT_W-1:0] HSIZE_LONG_ID   = 3'd4;

   typedef struct packed {
      logic             action;
      logic [7:0]       data_byte;
      logic             frame_last;
      logic [PID_W-1:0] new_picture_id;
   } req_type;

   typedef struct packed {
      logic [7:0]       out_byte;
      logic             is_header;
      logic             packet_end;
      logic             frame_end;
      logic [PID_W-1:0] current_picture_id;
   } rsp_type;

   // one classified byte: descriptor bytes to send first, then the data byte
   typedef struct packed {
      logic [HDR_CNT_W-1:0]        hdr_count;
      logic [HDR_MAX-1:0][7:0]     hdr_bytes;
      logic [7:0]                  data_byte;
      logic                        packet_end;
      logic                        frame_end;
      logic [PID_W-1:0]            frame_pid;
   } job_type;

endpackage

`default_nettype wire

@@ sv/vp8_rtp_packetizer_core.sv @@
// VP8 RTP packetizer, top level: front end, job queue and byte emitter.
// Depends on vrp_pkg, vrp_front, vrp_queue and vrp_back.
//
// Takes one VP8 frame byte per request and emits RTP payload bytes, each
// packet opened by its payload descriptor (1, 3 or 4 bytes) and at most mtu
// bytes long. A request is taken every cycle while the four-entry job queue
// has room; the emitter sends one byte per cycle while rsp_ready does not
// stall it, the descriptor bytes of a packet-opening job before its data
// byte. Picture ID loads and bytes dropped for a too-small mtu produce no
// response. Registers (mtu, picture_id_enable) are written through the csr
// port, by the user only while the block is idle; the block itself does not
// enforce it. An mtu change applies at once, also to an open packet; a
// picture_id_enable change applies at the next packet opening.
`default_nettype none

module vp8_rtp_packetizer_core (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      csr_wr_en,
   input  wire logic                      csr_addr,
   input  wire logic [vrp_pkg::MTU_W-1:0] csr_wdata,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire vrp_pkg::req_type          req_data,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output vrp_pkg::rsp_type               rsp_data
);
   import vrp_pkg::*;

   logic    q_full;
   logic    q_empty;
   logic    push;
   logic    pop;
   job_type push_job;
   job_type head_job;

   // front end: classify each request, pick the descriptor, track packet fill
   vrp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req       (req_data),
      .q_full    (q_full),
      .push      (push),
      .push_job  (push_job)
   );

   // decouples request intake from byte-by-byte header emission
   vrp_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .full     (q_full),
      .empty    (q_empty)
   );

   // emitter: descriptor bytes first, then the data byte, into the output reg
   vrp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .head_job  (head_job),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp       (rsp_data)
   );

   // descriptor bytes never close a packet
   a_hdr_no_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.is_header |-> !rsp_data.packet_end && !rsp_data.frame_end)
      else $error("descriptor byte flagged as packet end");

   // a frame end always closes its packet
   a_frame_closes_packet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.frame_end |-> rsp_data.packet_end)
      else $error("frame end without packet end");

   // a pushed job is never lost to a full queue
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !q_full)
      else $error("job pushed into full queue");

   // a full queue holds off requests
   a_full_stalls: assert property (@(posedge clock) disable iff (reset)
      q_full |-> !req_ready)
      else $error("request taken while queue full");

endmodule

`default_nettype wire

@@ sv/vrp_front.sv @@
// Front end: csr registers, packet/frame state and descriptor selection.
// Depends on vrp_pkg; pushes classified jobs into vrp_queue.
`default_nettype none

module vrp_front (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    csr_wr_en,
   input  wire logic                    csr_addr,
   input  wire logic [vrp_pkg::MTU_W-1:0] csr_wdata,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire vrp_pkg::req_type        req,
   input  wire logic                    q_full,
   output logic                         push,
   output vrp_pkg::job_type             push_job
);
   import vrp_pkg::*;

   logic [MTU_W-1:0]     mtu_ff, mtu_in;
   logic                 pid_en_ff, pid_en_in;
   logic [PID_W-1:0]     pid_ff, pid_in;
   logic [MTU_W-1:0]     fill_ff, fill_in;
   logic                 first_ff, first_in;

   logic                 take;
   logic                 ext;
   logic                 is_open;
   logic                 too_small;
   logic [HDR_CNT_W-1:0] hsize;
   logic [MTU_W-1:0]     fill_base;
   logic [MTU_W-1:0]     fill_sum;
   logic                 pend;

   assign req_ready = !q_full;
   assign take      = req_valid && req_ready;

   always_comb begin
      mtu_in    = mtu_ff;
      pid_en_in = pid_en_ff;
      if (csr_wr_en) begin
         unique case (csr_addr)
            CSR_MTU:    mtu_in    = csr_wdata;
            CSR_PID_EN: pid_en_in = csr_wdata[0];
            default:    mtu_in    = mtu_ff;
         endcase
      end
   end

   always_comb begin
      ext       = pid_en_ff && (pid_ff != '0);
      hsize     = !ext ? HSIZE_BASIC :
                  (pid_ff < PID_SHORT_LIMIT) ? HSIZE_SHORT_ID : HSIZE_LONG_ID;
      is_open   = (fill_ff == '0);
      too_small = (mtu_ff <= {{(MTU_W-HDR_CNT_W){1'b0}}, hsize});
      fill_base = is_open ? {{(MTU_W-HDR_CNT_W){1'b0}}, hsize} : fill_ff;
      // a stored fill is always below the mtu it was checked against, so this cannot wrap
      fill_sum  = fill_base + {{(MTU_W-1){1'b0}}, 1'b1};
      pend      = req.frame_last || (fill_sum >= mtu_ff);

      push_job.hdr_count    = is_open ? hsize : '0;
      push_job.hdr_bytes[0] = (first_ff ? HDR_S : 8'h00) | (ext ? HDR_X : 8'h00);
      push_job.hdr_bytes[1] = HDR_I;
      push_job.hdr_bytes[2] = (hsize == HSIZE_SHORT_ID) ? {1'b0, pid_ff[6:0]}
                                                        : (HDR_M | {1'b0, pid_ff[14:8]});
      push_job.hdr_bytes[3] = pid_ff[7:0];
      push_job.data_byte    = req.data_byte;
      push_job.packet_end   = pend;
      push_job.frame_end    = req.frame_last;
      push_job.frame_pid    = pid_ff;

      push     = 1'b0;
      pid_in   = pid_ff;
      fill_in  = fill_ff;
      first_in = first_ff;

      if (take) begin
         priority if (req.action == ACT_LOAD_ID) begin
            pid_in = req.new_picture_id;
         end else if (is_open && too_small) begin
            // byte dropped; a last byte still closes the frame
            if (req.frame_last) begin
               if (!first_ff) pid_in = pid_ff + 1'b1;
               first_in = 1'b1;
            end
         end else begin
            push    = 1'b1;
            fill_in = pend ? '0 : fill_sum;
            if (is_open) first_in = 1'b0;
            if (req.frame_last) begin
               pid_in   = pid_ff + 1'b1;
               first_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mtu_ff    <= MTU_RESET;
         pid_en_ff <= 1'b0;
         pid_ff    <= '0;
         fill_ff   <= '0;
         first_ff  <= 1'b1;
      end else begin
         mtu_ff    <= mtu_in;
         pid_en_ff <= pid_en_in;
         pid_ff    <= pid_in;
         fill_ff   <= fill_in;
         first_ff  <= first_in;
      end
   end

endmodule

`default_nettype wire

@@ sv/vrp_queue.sv @@
// Short job queue between front end and byte emitter.
// Depends on vrp_pkg for the job type and depth.
`default_nettype none

module vrp_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire vrp_pkg::job_type push_job,
   input  wire logic             pop,
   output vrp_pkg::job_type      head_job,
   output logic                  full,
   output logic                  empty
);
   import vrp_pkg::*;

   job_type             mem_ff [QDEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;

   assign full     = (count_ff == QCNT_W'(QDEPTH));
   assign empty    = (count_ff == '0);
   assign head_job = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      unique case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= push_job;
   end

endmodule

`default_nettype wire

@@ sv/vrp_back.sv @@
// Back end: walks each queued job out as descriptor bytes then the data byte.
// Depends on vrp_pkg; owns the registered response stage.
`default_nettype none

module vrp_back (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             q_empty,
   input  wire vrp_pkg::job_type head_job,
   output logic                  pop,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output vrp_pkg::rsp_type      rsp
);
   import vrp_pkg::*;

   rsp_type              rsp_ff, rsp_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [HDR_CNT_W-1:0] idx_ff, idx_in;
   logic                 out_free;
   logic                 in_hdr;
   logic                 load;

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   always_comb begin
      out_free = !rsp_valid_ff || rsp_ready;
      in_hdr   = (idx_ff < head_job.hdr_count);
      load     = out_free && !q_empty;
      pop      = load && !in_hdr;

      rsp_valid_in = out_free ? !q_empty : rsp_valid_ff;
      rsp_in       = rsp_ff;
      idx_in       = idx_ff;
      if (load) begin
         rsp_in.current_picture_id = head_job.frame_pid;
         if (in_hdr) begin
            rsp_in.out_byte   = head_job.hdr_bytes[idx_ff[HDR_IDX_W-1:0]];
            rsp_in.is_header  = 1'b1;
            rsp_in.packet_end = 1'b0;
            rsp_in.frame_end  = 1'b0;
            idx_in            = idx_ff + 1'b1;
         end else begin
            rsp_in.out_byte   = head_job.data_byte;
            rsp_in.is_header  = 1'b0;
            rsp_in.packet_end = head_job.packet_end;
            rsp_in.frame_end  = head_job.frame_end;
            idx_in            = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         idx_ff       <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

endmodule

`default_nettype wire

@@ sim/vp8_rtp_packetizer_core_tb.sv @@
// Self-checking testbench for vp8_rtp_packetizer_core.
// Depends on vrp_pkg and the packetizer RTL; a scoreboard class predicts
// descriptor and payload bytes for each accepted request.
`timescale 1ns / 100ps

module vp8_rtp_packetizer_core_tb;
   import vrp_pkg::*;

   localparam int CLK_HALF     = 6;
   localparam int RESET_CYCLES = 9;
   // Covers the deepest path: four queued jobs of up to five bytes each.
   localparam int SETTLE       = 24;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int N_PHASES     = 10;
   localparam int PHASE_ITEMS  = 25;

   // ---------------------------------------------------------------------
   // Scoreboard: keeps its own copy of the registers and packetizer state,
   // expands every accepted request into the bytes it should produce, and
   // compares responses in order.
   // ---------------------------------------------------------------------
   class packetizer_scoreboard;
      logic [MTU_W-1:0] mtu;
      logic             pid_en;
      logic [PID_W-1:0] pid;
      int               fill;        // bytes in the open packet, 0 = none open
      logic             first_pkt;   // next packet opens a frame
      rsp_type          expected_q[$];
      int               errors;

      function new();
         mtu       = MTU_RESET;
         pid_en    = 1'b0;
         pid       = '0;
         fill      = 0;
         first_pkt = 1'b1;
         errors    = 0;
      endfunction

      function void write_register(logic addr, logic [MTU_W-1:0] value);
         if (addr == CSR_MTU)
            mtu = value;
         else
            pid_en = value[0];
      endfunction

      function void push_byte(logic [7:0] b, logic hdr, logic pend, logic fend);
         rsp_type e;
         e.out_byte           = b;
         e.is_header          = hdr;
         e.packet_end         = pend;
         e.frame_end          = fend;
         e.current_picture_id = pid;
         expected_q.insert(expected_q.size(), e);
      endfunction

      function void note_request(req_type r);
         logic       ext;
         logic       pend;
         int         hsize;
         logic [7:0] b0;
         if (r.action == ACT_LOAD_ID) begin
            pid = r.new_picture_id;
            return;
         end
         if (fill == 0) begin
            ext = pid_en && (pid != '0);
            if (!ext)
               hsize = HSIZE_BASIC;
            else if (pid < PID_SHORT_LIMIT)
               hsize = HSIZE_SHORT_ID;
            else
               hsize = HSIZE_LONG_ID;
            // descriptor alone fills the packet: byte is dropped
            if (mtu <= hsize) begin
               if (r.frame_last) begin
                  if (!first_pkt)
                     pid = pid + 1'b1;
                  first_pkt = 1'b1;
               end
               return;
            end
            b0 = first_pkt ? HDR_S : '0;
            if (ext)
               b0 = b0 | HDR_X;
            push_byte(b0, 1'b1, 1'b0, 1'b0);
            if (ext) begin
               push_byte(HDR_I, 1'b1, 1'b0, 1'b0);
               if (hsize == HSIZE_SHORT_ID) begin
                  push_byte({1'b0, pid[6:0]}, 1'b1, 1'b0, 1'b0);
               end else begin
                  push_byte(HDR_M | {1'b0, pid[14:8]}, 1'b1, 1'b0, 1'b0);
                  push_byte(pid[7:0], 1'b1, 1'b0, 1'b0);
               end
            end
            first_pkt = 1'b0;
            fill      = hsize;
         end
         fill = fill + 1;
         pend = r.frame_last || (fill >= mtu);
         push_byte(r.data_byte, 1'b0, pend, r.frame_last);
         if (pend)
            fill = 0;
         if (r.frame_last) begin
            pid       = pid + 1'b1;
            first_pkt = 1'b1;
         end
      endfunction

      task report(string what, int got, int want);
         $display("ERROR: %s got 0x%0h, want 0x%0h", what, got, want);
         errors++;
      endtask

      task check_response(rsp_type r);
         rsp_type e;
         if (expected_q.size() == 0) begin
            report("response with nothing pending, out_byte", r.out_byte, 0);
            return;
         end
         e = expected_q.pop_front();
         if (r.out_byte !== e.out_byte)
            report("out_byte", r.out_byte, e.out_byte);
         if (r.is_header !== e.is_header)
            report("is_header", r.is_header, e.is_header);
         if (r.packet_end !== e.packet_end)
            report("packet_end", r.packet_end, e.packet_end);
         if (r.frame_end !== e.frame_end)
            report("frame_end", r.frame_end, e.frame_end);
         if (r.current_picture_id !== e.current_picture_id)
            report("current_picture_id", r.current_picture_id, e.current_picture_id);
      endtask
   endclass

   // ---------------------------------------------------------------------
   // DUT hookup; every input starts at a known value.
   // ---------------------------------------------------------------------
   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             csr_wr_en = 1'b0;
   logic             csr_addr  = 1'b0;
   logic [MTU_W-1:0] csr_wdata = '0;
   logic             req_valid = 1'b0;
   logic             req_ready;
   req_type          req_item  = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   rsp_type          rsp_item;

   packetizer_scoreboard sb;

   // idling controls, changed per phase
   logic gap_mode   = 1'b0;
   logic stall_mode = 1'b0;
   int   stall_left = 0;
   int   frame_left = 0;   // bytes still to send in the current random frame
   int   cycles     = 0;

   vp8_rtp_packetizer_core i_dut (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_item)
   );

   always #(CLK_HALF) clock = ~clock;

   // Watchdog: a hang or a missing response ends here.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // Mostly short idle stretches, now and then a long one.
   function automatic int idle_length();
      if ($urandom_range(0, 99) < 80)
         return $urandom_range(1, 3);
      return $urandom_range(6, 25);
   endfunction

   // Response side: check on handshake, then pick next cycle's ready.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready)
            sb.check_response(rsp_item);
         if (stall_left > 0) begin
            stall_left = stall_left - 1;
            rsp_ready <= 1'b0;
         end else if (stall_mode && $urandom_range(0, 99) < 25) begin
            stall_left = idle_length() - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Request driving. Valid is raised once and held until the handshake;
   // the scoreboard learns of a request only when it is accepted.
   // ---------------------------------------------------------------------
   task send_request(req_type r);
      int gap;
      gap = (gap_mode && $urandom_range(0, 99) < 35) ? idle_length() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_item  <= r;
      do
         @(posedge clock);
      while (!req_ready);
      sb.note_request(r);
   endtask

   // Frame byte; the unused ID field carries random bits.
   task put_byte(logic [7:0] data, logic last);
      req_type r;
      r.action         = ACT_DATA;
      r.data_byte      = data;
      r.frame_last     = last;
      r.new_picture_id = PID_W'($urandom);
      send_request(r);
   endtask

   // Picture ID load; data and last fields are don't-care, so randomize them.
   task load_id(logic [PID_W-1:0] id);
      req_type r;
      r.action         = ACT_LOAD_ID;
      r.data_byte      = 8'($urandom);
      r.frame_last     = 1'($urandom);
      r.new_picture_id = id;
      send_request(r);
   endtask

   // Request side goes quiet, then wait until nothing is expected, plus
   // a settling margin; dropped bytes never enter the job queue.
   task wait_idle();
      req_valid <= 1'b0;
      while (sb.expected_q.size() != 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task write_register(logic addr, logic [MTU_W-1:0] value);
      csr_wr_en <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= value;
      @(posedge clock);
      sb.write_register(addr, value);
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   task configure(logic [MTU_W-1:0] mtu, logic pid_en);
      wait_idle();
      write_register(CSR_MTU, mtu);
      write_register(CSR_PID_EN, {15'd0, pid_en});
   endtask

   function automatic logic [PID_W-1:0] random_id();
      case ($urandom_range(0, 4))
         0:       return '0;
         1:       return PID_W'($urandom_range(1, 127));
         2:       return PID_W'($urandom_range(128, 32767));
         3:       return '1;
         default: return PID_W'($urandom);
      endcase
   endfunction

   // Small mtus dominate so frames split into many packets.
   function automatic logic [MTU_W-1:0] random_mtu();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return MTU_W'($urandom_range(1, 4));
         2, 3, 4,
         5:       return MTU_W'($urandom_range(5, 12));
         6:       return MTU_W'($urandom_range(13, 64));
         7:       return MTU_RESET;
         8:       return '1;
         default: return MTU_W'($urandom);
      endcase
   endfunction

   // Mostly well-formed frames with random content, some ID loads between.
   task random_phase(int n);
      int i;
      for (i = 0; i < n; i++) begin
         if ($urandom_range(0, 99) < 8) begin
            load_id(random_id());
         end else begin
            if (frame_left == 0)
               frame_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                        : $urandom_range(1, 10);
            frame_left = frame_left - 1;
            put_byte(8'($urandom), frame_left == 0);
         end
      end
   endtask

   initial begin
      int p;
      sb = new();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // --- directed part ---
      // reset settings: plain one-byte descriptor, S on first packet only
      gap_mode   = 1'b0;
      stall_mode = 1'b0;
      put_byte(8'h00, 1'b0);
      put_byte(8'hFF, 1'b0);
      put_byte(8'hA5, 1'b1);

      // largest mtu, IDs on: long ID with wrap, zero ID, short ID limits
      configure('1, 1'b1);
      stall_mode = 1'b1;
      load_id('1);
      put_byte(8'h3C, 1'b0);
      put_byte(8'hC3, 1'b1);   // ID wraps to zero after this frame
      put_byte(8'h5A, 1'b1);   // zero ID: one-byte descriptor
      put_byte(8'h11, 1'b1);   // ID 1: short form
      load_id(PID_W'(127));
      put_byte(8'h22, 1'b1);
      put_byte(8'h33, 1'b1);   // ID 128: long form

      // tiny mtu splits a frame into several packets
      configure(MTU_W'(4), 1'b0);
      gap_mode = 1'b1;
      for (p = 0; p < 7; p++)
         put_byte(8'(p * 37), p == 6);

      // frame whose last byte is dropped after a packet went out: ID advances
      configure(MTU_W'(6), 1'b1);
      load_id(PID_W'(200));
      put_byte(8'h81, 1'b0);
      put_byte(8'h7E, 1'b0);   // fill hits mtu, packet closes
      configure(MTU_W'(4), 1'b1);
      put_byte(8'h44, 1'b1);

      // zero mtu: whole frame dropped, ID kept
      configure('0, 1'b1);
      put_byte(8'h99, 1'b1);

      // mtu lowered while a packet is open
      configure(MTU_W'(10), 1'b0);
      put_byte(8'h01, 1'b0);
      put_byte(8'h02, 1'b0);
      configure(MTU_W'(2), 1'b0);
      put_byte(8'h03, 1'b0);   // closes the open packet at once
      put_byte(8'h04, 1'b1);

      // --- random part ---
      for (p = 0; p < N_PHASES; p++) begin
         configure(random_mtu(), 1'($urandom));
         gap_mode   = ($urandom_range(0, 2) != 0);
         stall_mode = ($urandom_range(0, 2) != 0);
         random_phase(PHASE_ITEMS);
      end

      wait_idle();
      if (sb.errors == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
